>>> rtl/rdmp_pkg.sv
// ----------------------------------------------------------------------------
// rdmp_pkg: shared types and constants of the RDM response frame parser
// Status codes, field capture codes, command class and response type codes
// and the classified byte handed from the front end to the back end.
// ----------------------------------------------------------------------------
package rdmp_pkg;

	localparam int MAX_PARAM_BYTES = 231;
	localparam int HEADER_BYTES    = 24;

	localparam logic [7:0] START_CODE     = 8'hCC;
	localparam logic [7:0] SUB_START_CODE = 8'h01;
	localparam logic [9:0] COUNT_MAX      = 10'd1023;
	localparam logic [9:0] MIN_BYTES_RST  = 10'd26;

	// Running sum seed once the start pair is seen: 0xCC + 0x01
	localparam logic [15:0] SUM_SEED = 16'(START_CODE) + 16'(SUB_START_CODE);

	// Frame offsets of the header fields
	localparam logic [8:0] OFF_LENGTH    = 9'd2;
	localparam logic [8:0] OFF_UID_FIRST = 9'd9;
	localparam logic [8:0] OFF_UID_LAST  = 9'd14;
	localparam logic [8:0] OFF_COUNT     = 9'd17;
	localparam logic [8:0] OFF_CLASS     = 9'd20;
	localparam logic [8:0] OFF_PID_HI    = 9'd21;
	localparam logic [8:0] OFF_PID_LO    = 9'd22;
	localparam logic [8:0] OFF_PLEN      = 9'd23;

	// Command class low nibbles
	localparam logic [3:0] CC_ACK       = 4'h1;
	localparam logic [3:0] CC_ACK_TIMER = 4'h2;
	localparam logic [3:0] CC_NACK      = 4'h3;

	// Response type codes
	localparam logic [1:0] RT_ACK       = 2'd0;
	localparam logic [1:0] RT_ACK_TIMER = 2'd1;
	localparam logic [1:0] RT_NACK      = 2'd2;
	localparam logic [1:0] RT_INVALID   = 2'd3;

	typedef enum logic [2:0] {
		ST_OK,
		ST_SHORT,
		ST_NO_SYNC,
		ST_BAD_LENGTH,
		ST_BAD_CHECKSUM
	} status_t;

	typedef enum logic [2:0] {
		CAP_NONE,
		CAP_UID,
		CAP_COUNT,
		CAP_CLASS,
		CAP_PID,
		CAP_LENGTH,
		CAP_SUM_HI,
		CAP_SUM_LO
	} cap_t;

	typedef enum logic {
		KIND_PARAM,
		KIND_STATUS
	} kind_t;

	// One classified buffer byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		logic       sync_start;
		logic       sum_add;
		cap_t       cap;
		logic       emit;
		logic [7:0] pidx;
		status_t    pre_status;   // ST_OK here means the checksum still decides
		logic       len_bad;
	} op_t;

endpackage

>>> rtl/rdmp_if.sv
// ----------------------------------------------------------------------------
// rdmp_in_if / rdmp_out_if: byte and result channels
// Valid/ready channels; a transaction moves when valid and ready are high.
// ----------------------------------------------------------------------------
interface rdmp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last;

	modport source (output valid, output data_byte, output last, input ready);
	modport sink (input valid, input data_byte, input last, output ready);
endinterface

interface rdmp_out_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [7:0]  param_byte;
	logic [7:0]  param_index;
	logic [2:0]  status;
	logic [47:0] resp_uid;
	logic [1:0]  resp_type;
	logic [7:0]  msg_count;
	logic [15:0] pid;
	logic [7:0]  param_length;

	modport source (output valid, output kind, output param_byte, output param_index,
		output status, output resp_uid, output resp_type, output msg_count,
		output pid, output param_length, input ready);
	modport sink (input valid, input kind, input param_byte, input param_index,
		input status, input resp_uid, input resp_type, input msg_count,
		input pid, input param_length, output ready);
endinterface

>>> rtl/rdmp_front.sv
// ----------------------------------------------------------------------------
// rdmp_front: byte classifier
// Tracks sync, frame offset and length per buffer and tags each byte with
// the work the back end has to do on it.
// ----------------------------------------------------------------------------
module rdmp_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [9:0]     cfg_wdata,
	rdmp_in_if.sink        rx,
	output rdmp_pkg::op_t  op,
	output logic           op_valid,
	input  logic           op_ready
);
	import rdmp_pkg::*;

	logic [9:0] min_bytes_q;
	logic [7:0] prev_q;
	logic       sync_q;
	logic [8:0] off_q;
	logic [9:0] count_q;
	logic [7:0] flen_q;
	logic       cmpl_q;
	logic [7:0] plen_q;

	logic       sync_n;
	logic [8:0] off_n;
	logic [9:0] count_n;
	logic [7:0] flen_n;
	logic       cmpl_n;
	logic [7:0] plen_n;
	logic [8:0] rel;
	logic       accept;

	assign accept   = rx.valid && op_ready;
	assign rx.ready = op_ready;
	assign op_valid = rx.valid;

	always_comb begin
		sync_n  = sync_q;
		off_n   = off_q;
		flen_n  = flen_q;
		cmpl_n  = cmpl_q;
		plen_n  = plen_q;
		count_n = (count_q == COUNT_MAX) ? count_q : count_q + 10'd1;
		rel     = '0;

		op            = '0;
		op.data_byte  = rx.data_byte;
		op.last       = rx.last;
		op.cap        = CAP_NONE;
		op.pre_status = ST_OK;

		if (!sync_q) begin
			if (prev_q == START_CODE && rx.data_byte == SUB_START_CODE) begin
				sync_n        = 1'b1;
				off_n         = 9'd1;
				op.sync_start = 1'b1;
			end
		end else if (!cmpl_q) begin
			off_n = off_q + 9'd1;
			if (off_n == OFF_LENGTH)
				flen_n = rx.data_byte;
			op.sum_add = (off_n >= OFF_LENGTH) && (off_n < {1'b0, flen_n});
			if (off_n >= OFF_UID_FIRST && off_n <= OFF_UID_LAST)
				op.cap = CAP_UID;
			if (off_n == OFF_COUNT)
				op.cap = CAP_COUNT;
			if (off_n == OFF_CLASS)
				op.cap = CAP_CLASS;
			if (off_n == OFF_PID_HI || off_n == OFF_PID_LO)
				op.cap = CAP_PID;
			if (off_n == OFF_PLEN) begin
				op.cap = CAP_LENGTH;
				plen_n = rx.data_byte;
			end
			if ({1'b0, flen_n} >= 9'(HEADER_BYTES)) begin
				rel = off_n - 9'(HEADER_BYTES);
				if (off_n == {1'b0, flen_n})
					op.cap = CAP_SUM_HI;
				if (off_n == {1'b0, flen_n} + 9'd1) begin
					op.cap = CAP_SUM_LO;
					cmpl_n = 1'b1;
				end
				if (off_n >= 9'(HEADER_BYTES) && off_n < {1'b0, flen_n}
					&& rel < {1'b0, plen_n} && rel < 9'(MAX_PARAM_BYTES)) begin
					op.emit = 1'b1;
					op.pidx = rel[7:0];
				end
			end
		end

		// Status up to the checksum compare, which needs the back end's sums
		if (count_n < min_bytes_q)
			op.pre_status = ST_SHORT;
		else if (!sync_n)
			op.pre_status = ST_NO_SYNC;
		else if ({1'b0, flen_n} < 9'(HEADER_BYTES) || !cmpl_n)
			op.pre_status = ST_BAD_LENGTH;
		op.len_bad = ({1'b0, plen_n} > 9'(MAX_PARAM_BYTES))
			|| ((9'(HEADER_BYTES) + {1'b0, plen_n}) > {1'b0, flen_n});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_bytes_q <= MIN_BYTES_RST;
			prev_q      <= '0;
			sync_q      <= 1'b0;
			off_q       <= '0;
			count_q     <= '0;
			flen_q      <= '0;
			cmpl_q      <= 1'b0;
			plen_q      <= '0;
		end else begin
			if (cfg_we)
				min_bytes_q <= cfg_wdata;
			if (accept) begin
				if (rx.last) begin
					// drop all per-buffer state
					prev_q  <= '0;
					sync_q  <= 1'b0;
					off_q   <= '0;
					count_q <= '0;
					flen_q  <= '0;
					cmpl_q  <= 1'b0;
					plen_q  <= '0;
				end else begin
					prev_q  <= rx.data_byte;
					sync_q  <= sync_n;
					off_q   <= off_n;
					count_q <= count_n;
					flen_q  <= flen_n;
					cmpl_q  <= cmpl_n;
					plen_q  <= plen_n;
				end
			end
		end
	end

endmodule

>>> rtl/rdmp_queue.sv
// ----------------------------------------------------------------------------
// rdmp_queue: classified byte FIFO
// Short FIFO between the classifier and the executor.
// ----------------------------------------------------------------------------
module rdmp_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  rdmp_pkg::op_t  push_op,
	input  logic           push_valid,
	output logic           push_ready,
	output rdmp_pkg::op_t  pop_op,
	output logic           pop_valid,
	input  logic           pop_ready
);
	import rdmp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	op_t           mem [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          push;
	logic          pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_op     = mem[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
			if (pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CW'(1);
		end
	end

endmodule

>>> rtl/rdmp_back.sv
// ----------------------------------------------------------------------------
// rdmp_back: frame executor
// Keeps the checksum and header fields, settles the final status and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module rdmp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  rdmp_pkg::op_t  op,
	input  logic           op_valid,
	output logic           op_ready,
	rdmp_out_if.source     result
);
	import rdmp_pkg::*;

	logic [15:0] sum_q, recv_q;
	logic [47:0] uid_q;
	logic [7:0]  count_q, class_q, plen_q;
	logic [15:0] pid_q;

	logic [15:0] sum_n, recv_n;
	logic [47:0] uid_n;
	logic [7:0]  count_n, class_n, plen_n;
	logic [15:0] pid_n;
	status_t     final_st;
	logic        pop;

	logic        valid_q;
	logic        kind_q;
	logic [7:0]  pbyte_q, pidx_q, mcount_q, plength_q;
	logic [2:0]  status_q;
	logic [47:0] suid_q;
	logic [1:0]  rtype_q;
	logic [15:0] rpid_q;

	function automatic logic [1:0] response_kind(input logic [7:0] cls);
		logic [1:0] r;
		case (cls[3:0])
			CC_ACK:       r = RT_ACK;
			CC_ACK_TIMER: r = RT_ACK_TIMER;
			CC_NACK:      r = RT_NACK;
			default:      r = RT_INVALID;
		endcase
		return r;
	endfunction

	assign op_ready = !valid_q || result.ready;
	assign pop      = op_valid && op_ready;

	always_comb begin
		sum_n   = sum_q;
		recv_n  = recv_q;
		uid_n   = uid_q;
		count_n = count_q;
		class_n = class_q;
		pid_n   = pid_q;
		plen_n  = plen_q;
		if (op.sync_start)
			sum_n = SUM_SEED;
		else if (op.sum_add)
			sum_n = sum_q + {8'd0, op.data_byte};
		case (op.cap)
			CAP_UID:    uid_n   = {uid_q[39:0], op.data_byte};
			CAP_COUNT:  count_n = op.data_byte;
			CAP_CLASS:  class_n = op.data_byte;
			CAP_PID:    pid_n   = {pid_q[7:0], op.data_byte};
			CAP_LENGTH: plen_n  = op.data_byte;
			CAP_SUM_HI: recv_n  = {op.data_byte, 8'd0};
			CAP_SUM_LO: recv_n  = recv_q | {8'd0, op.data_byte};
			default:    ;
		endcase

		final_st = op.pre_status;
		if (op.pre_status == ST_OK) begin
			if (sum_n != recv_n)
				final_st = ST_BAD_CHECKSUM;
			else if (op.len_bad)
				final_st = ST_BAD_LENGTH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= '0;
			recv_q  <= '0;
			uid_q   <= '0;
			count_q <= '0;
			class_q <= '0;
			pid_q   <= '0;
			plen_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			// a pop implies the held result, if any, leaves this cycle
			if (pop)
				valid_q <= op.last || op.emit;
			else if (result.valid && result.ready)
				valid_q <= 1'b0;
			if (pop) begin
				if (op.last) begin
					sum_q   <= '0;
					recv_q  <= '0;
					uid_q   <= '0;
					count_q <= '0;
					class_q <= '0;
					pid_q   <= '0;
					plen_q  <= '0;
				end else begin
					sum_q   <= sum_n;
					recv_q  <= recv_n;
					uid_q   <= uid_n;
					count_q <= count_n;
					class_q <= class_n;
					pid_q   <= pid_n;
					plen_q  <= plen_n;
				end
			end
		end
	end

	// Result payload; header fields only travel with an ok status
	always_ff @(posedge clk) begin
		if (pop && (op.last || op.emit)) begin
			kind_q    <= op.last ? KIND_STATUS : KIND_PARAM;
			pbyte_q   <= op.last ? 8'd0 : op.data_byte;
			pidx_q    <= op.last ? 8'd0 : op.pidx;
			status_q  <= op.last ? final_st : ST_OK;
			if (op.last && final_st == ST_OK) begin
				suid_q    <= uid_n;
				rtype_q   <= response_kind(class_n);
				mcount_q  <= count_n;
				rpid_q    <= pid_n;
				plength_q <= plen_n;
			end else begin
				suid_q    <= '0;
				rtype_q   <= '0;
				mcount_q  <= '0;
				rpid_q    <= '0;
				plength_q <= '0;
			end
		end
	end

	assign result.valid         = valid_q;
	assign result.kind          = kind_q;
	assign result.param_byte    = pbyte_q;
	assign result.param_index   = pidx_q;
	assign result.status        = status_q;
	assign result.resp_uid      = suid_q;
	assign result.resp_type     = rtype_q;
	assign result.msg_count     = mcount_q;
	assign result.pid           = rpid_q;
	assign result.param_length  = plength_q;

endmodule

>>> rtl/rdm_response_frame_parser.sv
// ----------------------------------------------------------------------------
// rdm_response_frame_parser: RDM response frame parser
// Parses one receive buffer per burst of bytes and reports parameter bytes
// and a final status per buffer.
// ----------------------------------------------------------------------------
// Takes one buffer byte per clock on rx, sustained while the result side is
// ready, with last marking the buffer end. A byte's result, if any, is
// registered in the queue entry and then in the executor output register
// (the classifier is combinational). The classifier tracks the start pair,
// frame offset and length; the executor holds the 16-bit checksum and
// header fields. Parameter bytes stream out as kind 0 and must be kept by
// the consumer only if the kind 1 status that ends the buffer is ok. A
// stalled result side backs up through the QUEUE_DEPTH-entry queue to
// rx.ready. The user must write min_buffer_bytes through cfg_we/cfg_wdata
// only while idle; the block itself does not enforce this.
module rdm_response_frame_parser #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [9:0] cfg_wdata,
	rdmp_in_if.sink    rx,
	rdmp_out_if.source result
);
	import rdmp_pkg::*;

	op_t  front_op;
	logic front_valid;
	logic front_ready;
	op_t  back_op;
	logic back_valid;
	logic back_ready;

	rdmp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx),
		.op        (front_op),
		.op_valid  (front_valid),
		.op_ready  (front_ready)
	);

	rdmp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_op    (front_op),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_op     (back_op),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	rdmp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (back_op),
		.op_valid (back_valid),
		.op_ready (back_ready),
		.result   (result)
	);

endmodule

>>> tb/rdm_response_frame_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdm_response_frame_parser_tb: self-checking bench for the RDM response parser
// Feeds receive buffers byte by byte (directed frames, then random frames and
// noise), predicts parameter bytes and final status in a model of its own, and
// compares every result transaction field by field under random back-pressure.
// ----------------------------------------------------------------------------
module rdm_response_frame_parser_tb;
	import rdmp_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 100;

	typedef struct {
		kind_t       kind;
		logic [7:0]  param_byte;
		logic [7:0]  param_index;
		status_t     status;
		logic [47:0] resp_uid;
		logic [1:0]  resp_type;
		logic [7:0]  msg_count;
		logic [15:0] pid;
		logic [7:0]  param_length;
	} parse_result_t;

	// One receive buffer to build: optional junk, optional frame, tail, cut
	typedef struct {
		int      min_bytes;   // -1 keeps the current setting
		int      junk;
		bit      noisy;       // junk may hold any byte value
		bit      framed;
		int      msg_len;
		int      plen;
		bit      corrupt;
		int      extra;
		int      cut;
		bit      edge_pair;   // first byte 0x01, last byte 0xCC
		bit      typed;
		status_t want;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [9:0] cfg_wdata;

	rdmp_in_if  rx_ch();
	rdmp_out_if res_ch();

	rdm_response_frame_parser u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx_ch),
		.result    (res_ch)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// Parser state as predicted
	logic [7:0]  pr_prev;
	bit          pr_synced;
	logic [8:0]  pr_offset;
	logic [9:0]  pr_count;
	logic [7:0]  pr_len;
	logic [15:0] pr_sum;
	logic [15:0] pr_rx_sum;
	bit          pr_done;
	logic [47:0] pr_uid;
	logic [7:0]  pr_msg_count;
	logic [7:0]  pr_class;
	logic [15:0] pr_pid;
	logic [7:0]  pr_plen;
	logic [9:0]  short_limit;

	parse_result_t due_results[$];
	logic [7:0]    buffer_bytes[$];
	int            failures;
	int            quiet_cycles;
	bit            calm;
	bit            hold_req;

	function automatic void clear_parser();
		pr_prev      = '0;
		pr_synced    = 1'b0;
		pr_offset    = '0;
		pr_count     = '0;
		pr_len       = '0;
		pr_sum       = '0;
		pr_rx_sum    = '0;
		pr_done      = 1'b0;
		pr_uid       = '0;
		pr_msg_count = '0;
		pr_class     = '0;
		pr_pid       = '0;
		pr_plen      = '0;
	endfunction

	// Advance the predicted parser by one byte; returns 1 when a result is due
	function automatic bit parse_step(input logic [7:0] b, input logic lst,
		output parse_result_t r);
		bit         emit;
		logic [7:0] pidx;
		int         off;
		int         fl;
		r.kind          = KIND_PARAM;
		r.param_byte    = '0;
		r.param_index   = '0;
		r.status        = ST_OK;
		r.resp_uid      = '0;
		r.resp_type     = '0;
		r.msg_count     = '0;
		r.pid           = '0;
		r.param_length  = '0;
		emit = 1'b0;
		pidx = '0;
		if (pr_count < COUNT_MAX)
			pr_count++;
		if (!pr_synced) begin
			if (pr_prev == START_CODE && b == SUB_START_CODE) begin
				pr_synced = 1'b1;
				pr_offset = 9'd1;
				pr_sum    = SUM_SEED;
			end
		end else if (!pr_done) begin
			pr_offset = pr_offset + 9'd1;
			off = int'(pr_offset);
			if (pr_offset == OFF_LENGTH)
				pr_len = b;
			fl = int'(pr_len);
			if (off >= 2 && off < fl)
				pr_sum = pr_sum + 16'(b);
			if (pr_offset >= OFF_UID_FIRST && pr_offset <= OFF_UID_LAST)
				pr_uid = {pr_uid[39:0], b};
			if (pr_offset == OFF_COUNT)
				pr_msg_count = b;
			if (pr_offset == OFF_CLASS)
				pr_class = b;
			if (pr_offset == OFF_PID_HI || pr_offset == OFF_PID_LO)
				pr_pid = {pr_pid[7:0], b};
			if (pr_offset == OFF_PLEN)
				pr_plen = b;
			if (fl >= HEADER_BYTES && off == fl)
				pr_rx_sum = {b, 8'h00};
			if (fl >= HEADER_BYTES && off == fl + 1) begin
				pr_rx_sum[7:0] = b;
				pr_done = 1'b1;
			end
			if (fl >= HEADER_BYTES && off >= HEADER_BYTES && off < fl &&
					off - HEADER_BYTES < int'(pr_plen) &&
					off - HEADER_BYTES < MAX_PARAM_BYTES) begin
				emit = 1'b1;
				pidx = 8'(off - HEADER_BYTES);
			end
		end
		pr_prev = b;

		if (lst) begin
			r.kind = KIND_STATUS;
			if (pr_count < short_limit)
				r.status = ST_SHORT;
			else if (!pr_synced)
				r.status = ST_NO_SYNC;
			else if (int'(pr_len) < HEADER_BYTES || !pr_done)
				r.status = ST_BAD_LENGTH;
			else if (pr_sum != pr_rx_sum)
				r.status = ST_BAD_CHECKSUM;
			else if (int'(pr_plen) > MAX_PARAM_BYTES ||
					HEADER_BYTES + int'(pr_plen) > int'(pr_len))
				r.status = ST_BAD_LENGTH;
			if (r.status == ST_OK) begin
				r.resp_uid      = pr_uid;
				r.msg_count     = pr_msg_count;
				r.pid           = pr_pid;
				r.param_length  = pr_plen;
				case (pr_class[3:0])
					CC_ACK:       r.resp_type = RT_ACK;
					CC_ACK_TIMER: r.resp_type = RT_ACK_TIMER;
					CC_NACK:      r.resp_type = RT_NACK;
					default:      r.resp_type = RT_INVALID;
				endcase
			end
			clear_parser();
			return 1'b1;
		end
		if (emit) begin
			r.param_byte  = b;
			r.param_index = pidx;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic build_buffer(input stim_row_t s);
		logic [7:0]  frame[$];
		logic [7:0]  b;
		logic [3:0]  nib;
		logic [15:0] csum;
		int          frame_len;
		int          i;
		buffer_bytes.delete();
		repeat (s.junk) begin
			b = 8'($urandom_range(0, 255));
			// keep plain junk free of start codes
			if (!s.noisy && b == START_CODE)
				b = ~b;
			buffer_bytes.push_back(b);
		end
		if (s.framed) begin
			frame_len = (s.msg_len < 1) ? 3 : s.msg_len + 2;
			repeat (frame_len)
				frame.push_back(8'($urandom_range(0, 255)));
			frame[0] = START_CODE;
			frame[1] = SUB_START_CODE;
			frame[2] = 8'(s.msg_len);
			if (frame_len > 20) begin
				case ($urandom_range(0, 3))
					0: nib = CC_ACK;
					1: nib = CC_ACK_TIMER;
					2: nib = CC_NACK;
					default: nib = 4'($urandom_range(0, 15));
				endcase
				frame[20] = {frame[20][7:4], nib};
			end
			if (frame_len > 23)
				frame[23] = 8'(s.plen);
			if (s.msg_len >= HEADER_BYTES) begin
				csum = '0;
				for (i = 0; i < s.msg_len; i++)
					csum = csum + 16'(frame[i]);
				if (s.corrupt)
					csum = csum ^ 16'($urandom_range(1, 65535));
				frame[s.msg_len]     = csum[15:8];
				frame[s.msg_len + 1] = csum[7:0];
			end
			foreach (frame[k])
				buffer_bytes.push_back(frame[k]);
		end
		repeat (s.extra)
			buffer_bytes.push_back(8'($urandom_range(0, 255)));
		repeat (s.cut)
			void'(buffer_bytes.pop_back());
		if (s.edge_pair) begin
			buffer_bytes[0] = SUB_START_CODE;
			buffer_bytes[buffer_bytes.size() - 1] = START_CODE;
		end
		if (buffer_bytes.size() == 0)
			buffer_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// Offer the built buffer; record what each accepted byte should produce
	task automatic send_buffer(input bit typed, input status_t want);
		parse_result_t r;
		logic          lst;
		int            gap;
		int            i;
		calm = ($urandom_range(0, 4) == 0);
		for (i = 0; i < buffer_bytes.size(); i++) begin
			lst = (i == buffer_bytes.size() - 1);
			gap = calm ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				rx_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rx_ch.valid     <= 1'b1;
			rx_ch.data_byte <= buffer_bytes[i];
			rx_ch.last      <= lst;
			do @(posedge clk); while (!rx_ch.ready);
			if (parse_step(buffer_bytes[i], lst, r)) begin
				if (lst && typed) begin
					r.status = want;
					if (want != ST_OK) begin
						r.resp_uid      = '0;
						r.resp_type     = '0;
						r.msg_count     = '0;
						r.pid           = '0;
						r.param_length  = '0;
					end
				end
				due_results.push_back(r);
			end
		end
	endtask

	// Drain, let in-flight bytes settle, then write the short threshold
	task automatic write_min(input logic [9:0] v);
		rx_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we      <= 1'b0;
		short_limit = v;
	endtask

	task automatic compare_result(input parse_result_t e);
		if (res_ch.kind !== e.kind) begin
			$error("kind: expected %0d, got %0d", e.kind, res_ch.kind);
			failures++;
		end
		if (res_ch.param_byte !== e.param_byte) begin
			$error("param_byte: expected %0h, got %0h", e.param_byte, res_ch.param_byte);
			failures++;
		end
		if (res_ch.param_index !== e.param_index) begin
			$error("param_index: expected %0d, got %0d", e.param_index, res_ch.param_index);
			failures++;
		end
		if (res_ch.status !== e.status) begin
			$error("status: expected %0d, got %0d", e.status, res_ch.status);
			failures++;
		end
		if (res_ch.resp_uid !== e.resp_uid) begin
			$error("resp_uid: expected %0h, got %0h", e.resp_uid, res_ch.resp_uid);
			failures++;
		end
		if (res_ch.resp_type !== e.resp_type) begin
			$error("resp_type: expected %0d, got %0d", e.resp_type,
				res_ch.resp_type);
			failures++;
		end
		if (res_ch.msg_count !== e.msg_count) begin
			$error("msg_count: expected %0h, got %0h", e.msg_count,
				res_ch.msg_count);
			failures++;
		end
		if (res_ch.pid !== e.pid) begin
			$error("pid: expected %0h, got %0h", e.pid, res_ch.pid);
			failures++;
		end
		if (res_ch.param_length !== e.param_length) begin
			$error("param_length: expected %0d, got %0d", e.param_length,
				res_ch.param_length);
			failures++;
		end
	endtask

	// Result side: random stalls, one long hold-off on request
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 8);
			if (hold_req) begin
				stall    = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
			if (due_results.size() == 0) begin
				$error("unexpected result transaction: kind %0d status %0d",
					res_ch.kind, res_ch.status);
				failures++;
			end else begin
				compare_result(due_results.pop_front());
			end
		end
	end

	// Abort when no transaction moves on either channel for too long
	always @(posedge clk) begin
		if ((rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		stim_row_t  dir_rows[$];
		stim_row_t  r;
		logic [9:0] phase_min[5];
		int         quota;
		int         sent;
		int         pick;
		int         p;
		bit         first_random;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		rx_ch.valid     = 1'b0;
		rx_ch.data_byte = '0;
		rx_ch.last      = 1'b0;
		failures        = 0;
		quiet_cycles    = 0;
		calm            = 1'b0;
		hold_req        = 1'b0;
		short_limit     = MIN_BYTES_RST;
		clear_parser();

		//                      min junk nz fr len plen bad ext cut edg typ want
		dir_rows.push_back(stim_row_t'{-1, 3, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_SHORT});
		dir_rows.push_back(stim_row_t'{-1, 25, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_SHORT});
		dir_rows.push_back(stim_row_t'{-1, 26, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NO_SYNC});
		dir_rows.push_back(stim_row_t'{-1, 0, 0, 1, 24, 0, 0, 0, 0, 0, 1, ST_OK});
		dir_rows.push_back(stim_row_t'{-1, 0, 0, 1, 30, 6, 1, 0, 0, 0, 1, ST_BAD_CHECKSUM});
		dir_rows.push_back(stim_row_t'{-1, 0, 0, 1, 10, 0, 0, 14, 0, 0, 1, ST_BAD_LENGTH});
		dir_rows.push_back(stim_row_t'{-1, 0, 0, 1, 0, 0, 0, 23, 0, 0, 1, ST_BAD_LENGTH});
		dir_rows.push_back(stim_row_t'{-1, 2, 0, 1, 40, 10, 0, 0, 1, 0, 1, ST_BAD_LENGTH});
		dir_rows.push_back(stim_row_t'{-1, 0, 0, 1, 30, 7, 0, 0, 0, 0, 1, ST_BAD_LENGTH});
		dir_rows.push_back(stim_row_t'{-1, 0, 0, 1, 30, 232, 0, 0, 0, 0, 1, ST_BAD_LENGTH});
		dir_rows.push_back(stim_row_t'{-1, 2, 0, 1, 26, 2, 0, 3, 0, 0, 0, ST_OK});
		// start pair split over two buffers must not sync
		dir_rows.push_back(stim_row_t'{-1, 26, 0, 0, 0, 0, 0, 0, 0, 1, 1, ST_NO_SYNC});
		dir_rows.push_back(stim_row_t'{-1, 26, 0, 0, 0, 0, 0, 0, 0, 1, 1, ST_NO_SYNC});
		dir_rows.push_back(stim_row_t'{0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1, ST_NO_SYNC});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].min_bytes >= 0)
				write_min(10'(dir_rows[i].min_bytes));
			build_buffer(dir_rows[i]);
			send_buffer(dir_rows[i].typed, dir_rows[i].want);
		end

		phase_min[0] = MIN_BYTES_RST;
		phase_min[1] = 10'd0;
		phase_min[2] = COUNT_MAX;
		phase_min[3] = 10'($urandom_range(1, 60));
		phase_min[4] = MIN_BYTES_RST;
		first_random = 1'b1;
		for (p = 0; p < 5; p++) begin
			write_min(phase_min[p]);
			quota = (phase_min[p] == COUNT_MAX) ? 15 : 30;
			sent  = 0;
			while (sent < quota) begin
				pick = $urandom_range(0, 9);
				// open with a frame while the result side holds off
				if (first_random) begin
					pick         = 0;
					hold_req     = 1'b1;
					first_random = 1'b0;
				end
				r.min_bytes = -1;
				r.junk      = $urandom_range(0, 3);
				r.noisy     = ($urandom_range(0, 3) == 0);
				r.framed    = 1'b1;
				r.msg_len   = 0;
				r.plen      = 0;
				r.corrupt   = 1'b0;
				r.extra     = 0;
				r.cut       = 0;
				r.edge_pair = 1'b0;
				r.typed     = 1'b0;
				r.want      = ST_OK;
				if (pick <= 6) begin
					r.msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 255)
						: $urandom_range(24, 48);
					r.plen = (pick == 6) ? $urandom_range(0, 255)
						: $urandom_range(0, r.msg_len - HEADER_BYTES);
					r.corrupt = ($urandom_range(0, 7) == 0);
					r.extra   = $urandom_range(0, 3);
					r.cut     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0;
				end else if (pick == 7) begin
					r.msg_len = $urandom_range(0, 23);
					r.extra   = $urandom_range(0, 30);
				end else begin
					r.framed = 1'b0;
					r.junk   = $urandom_range(1, 40);
					r.noisy  = (pick == 9);
				end
				build_buffer(r);
				sent += buffer_bytes.size();
				send_buffer(1'b0, ST_OK);
			end
		end

		rx_ch.valid <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
